// ===== hdl/i4p_pkg.sv =====
// Shared types, constants and pixel arithmetic for the intra 4x4 luma predictor.
`default_nettype none

package i4p_pkg;

    localparam logic [7:0] PIX_MID = 8'h80;

    typedef enum logic [3:0] {
        MODE_VERT = 4'd0,
        MODE_HOR  = 4'd1,
        MODE_DC   = 4'd2,
        MODE_DDL  = 4'd3,
        MODE_DDR  = 4'd4,
        MODE_VR   = 4'd5,
        MODE_HD   = 4'd6,
        MODE_VL   = 4'd7,
        MODE_HU   = 4'd8
    } t_mode;

    typedef logic [7:0][7:0] t_top;
    typedef logic [3:0][7:0] t_left;
    typedef logic [3:0][3:0][7:0] t_rows;

    typedef struct packed {
        logic up_right;
        logic up_left;
        logic left;
        logic up;
    } t_avail;

    typedef struct packed {
        logic [3:0] mode;
        logic [3:0] block_index;
        logic       top_edge;
        logic       left_edge;
        logic       top_left_edge;
        logic       top_right_edge;
        t_top       above_pixels;
        t_left      left_pixels;
        logic [7:0] corner_pixel;
    } t_req;

    typedef struct packed {
        t_top       top;
        t_left      left;
        logic [7:0] corner;
    } t_nbr;

    // Neighbour availability per block position in macroblock decode order.
    function automatic t_avail avail_flags(logic [3:0] idx, logic te, logic le,
                                           logic tle, logic tre);
        t_avail f;
        logic   t;
        logic   l;
        t = ~te;
        l = ~le;
        unique case (idx) inside
            4'd0: begin
                f.up       = t;
                f.up_right = t;
                f.left     = l;
                f.up_left  = (t | l) & ~tle;
            end
            4'd1, 4'd4: begin
                f.up       = t;
                f.up_right = t;
                f.up_left  = t;
                f.left     = 1'b1;
            end
            4'd5: begin
                f.up       = t;
                f.up_right = t & ~tre;
                f.up_left  = t;
                f.left     = 1'b1;
            end
            4'd2, 4'd8, 4'd10: begin
                f.up       = 1'b1;
                f.up_right = 1'b1;
                f.left     = l;
                f.up_left  = l;
            end
            4'd6, 4'd9, 4'd12, 4'd14: begin
                f = '{up_right: 1'b1, up_left: 1'b1, left: 1'b1, up: 1'b1};
            end
            default: begin
                f = '{up_right: 1'b0, up_left: 1'b1, left: 1'b1, up: 1'b1};
            end
        endcase
        return f;
    endfunction

    // Neighbour at (x, y): y = -1 is the row above, x = -1 the column left.
    function automatic logic [7:0] nb(t_nbr n, int x, int y);
        logic [7:0] p;
        if (y < 0) begin
            if (x < 0) begin
                p = n.corner;
            end else begin
                p = n.top[x[2:0]];
            end
        end else begin
            p = n.left[y[1:0]];
        end
        return p;
    endfunction

    function automatic logic [7:0] avg2(logic [7:0] a, logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

    function automatic logic [7:0] avg3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [9:0] s;
        s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + 10'd2;
        return s[9:2];
    endfunction

    // One predicted pixel; x and y are fixed per instance, so each folds to a mode mux.
    function automatic logic [7:0] pred_pixel(logic [3:0] mode, int x, int y,
                                              t_nbr n, logic [7:0] dc);
        logic [7:0] p;
        int         z;
        p = 8'd0;
        z = 0;
        case (t_mode'(mode))
            MODE_VERT: p = nb(n, x, -1);
            MODE_HOR:  p = nb(n, -1, y);
            MODE_DC:   p = dc;
            MODE_DDL: begin
                if (x == 3 && y == 3) begin
                    p = avg3(nb(n, 6, -1), nb(n, 7, -1), nb(n, 7, -1));
                end else begin
                    p = avg3(nb(n, x + y, -1), nb(n, x + y + 1, -1), nb(n, x + y + 2, -1));
                end
            end
            MODE_DDR: begin
                if (x > y) begin
                    p = avg3(nb(n, x - y - 2, -1), nb(n, x - y - 1, -1), nb(n, x - y, -1));
                end else if (x < y) begin
                    p = avg3(nb(n, -1, y - x - 2), nb(n, -1, y - x - 1), nb(n, -1, y - x));
                end else begin
                    p = avg3(nb(n, 0, -1), nb(n, -1, -1), nb(n, -1, 0));
                end
            end
            MODE_VR: begin
                z = 2 * x - y;
                if (z >= 0 && z[0] == 1'b0) begin
                    p = avg2(nb(n, x - (y >> 1) - 1, -1), nb(n, x - (y >> 1), -1));
                end else if (z > 0) begin
                    p = avg3(nb(n, x - (y >> 1) - 2, -1), nb(n, x - (y >> 1) - 1, -1),
                             nb(n, x - (y >> 1), -1));
                end else if (z == -1) begin
                    p = avg3(nb(n, -1, 0), nb(n, -1, -1), nb(n, 0, -1));
                end else begin
                    p = avg3(nb(n, -1, y - 1), nb(n, -1, y - 2), nb(n, -1, y - 3));
                end
            end
            MODE_HD: begin
                z = 2 * y - x;
                if (z >= 0 && z[0] == 1'b0) begin
                    p = avg2(nb(n, -1, y - (x >> 1) - 1), nb(n, -1, y - (x >> 1)));
                end else if (z > 0) begin
                    p = avg3(nb(n, -1, y - (x >> 1) - 2), nb(n, -1, y - (x >> 1) - 1),
                             nb(n, -1, y - (x >> 1)));
                end else if (z == -1) begin
                    p = avg3(nb(n, -1, 0), nb(n, -1, -1), nb(n, 0, -1));
                end else begin
                    p = avg3(nb(n, x - 1, -1), nb(n, x - 2, -1), nb(n, x - 3, -1));
                end
            end
            MODE_VL: begin
                if (y[0] == 1'b0) begin
                    p = avg2(nb(n, x + (y >> 1), -1), nb(n, x + (y >> 1) + 1, -1));
                end else begin
                    p = avg3(nb(n, x + (y >> 1), -1), nb(n, x + (y >> 1) + 1, -1),
                             nb(n, x + (y >> 1) + 2, -1));
                end
            end
            MODE_HU: begin
                z = x + 2 * y;
                if (z < 5 && z[0] == 1'b0) begin
                    p = avg2(nb(n, -1, y + (x >> 1)), nb(n, -1, y + (x >> 1) + 1));
                end else if (z < 5) begin
                    p = avg3(nb(n, -1, y + (x >> 1)), nb(n, -1, y + (x >> 1) + 1),
                             nb(n, -1, y + (x >> 1) + 2));
                end else if (z == 5) begin
                    p = avg3(nb(n, -1, 2), nb(n, -1, 3), nb(n, -1, 3));
                end else begin
                    p = nb(n, -1, 3);
                end
            end
            default: p = 8'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/i4p_pred.sv =====
// Neighbour substitution, DC mean and the nine 4x4 prediction modes for one block.
`default_nettype none

module i4p_pred (
    input  wire i4p_pkg::t_req  i_req,
    output i4p_pkg::t_rows      o_rows
);
    import i4p_pkg::*;

    t_avail     avail;
    t_nbr       nbr;
    logic [9:0] sum_top;
    logic [9:0] sum_left;
    logic [11:0] sum_all;
    logic [9:0] mean_one;
    logic [7:0] dc;

    assign avail = avail_flags(i_req.block_index, i_req.top_edge, i_req.left_edge,
                               i_req.top_left_edge, i_req.top_right_edge);

    // Missing neighbours take mid grey; a missing up-right run repeats pixel D.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            nbr.top[i]  = avail.up ? i_req.above_pixels[i] : PIX_MID;
            nbr.left[i] = avail.left ? i_req.left_pixels[i] : PIX_MID;
        end
        for (int i = 4; i < 8; i++) begin
            nbr.top[i] = avail.up_right ? i_req.above_pixels[i] : nbr.top[3];
        end
        nbr.corner = avail.up_left ? i_req.corner_pixel : PIX_MID;
    end

    always_comb begin
        sum_top  = {2'b00, nbr.top[0]} + {2'b00, nbr.top[1]}
                 + {2'b00, nbr.top[2]} + {2'b00, nbr.top[3]};
        sum_left = {2'b00, nbr.left[0]} + {2'b00, nbr.left[1]}
                 + {2'b00, nbr.left[2]} + {2'b00, nbr.left[3]};
        sum_all  = {2'b00, sum_top} + {2'b00, sum_left} + 12'd4;
        mean_one = (avail.up ? sum_top : sum_left) + 10'd2;
        if (avail.up && avail.left) begin
            dc = sum_all[10:3];
        end else if (avail.up || avail.left) begin
            dc = mean_one[9:2];
        end else begin
            dc = PIX_MID;
        end
    end

    for (genvar gy = 0; gy < 4; gy++) begin : g_row
        for (genvar gx = 0; gx < 4; gx++) begin : g_col
            assign o_rows[gy][gx] = pred_pixel(i_req.mode, gx, gy, nbr, dc);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/intra4x4_luma_predictor_core.sv =====
// Top level of the intra 4x4 luma predictor: input register, predictor, result register.
`default_nettype none

// Channel   Dir  Width  Contents
// s_axis    in   112    one block request: neighbours, edge bits, block index; mode in tuser
// m_axis    out  128    four predicted rows, row 0 in the lowest 32 bits
//
// Each item passes through two registers: the request is captured in the input
// register at the accepting edge, predicted by the combinational stage and loaded
// into the result register once that register is free; m_axis_tvalid rises when
// it is loaded. One item can be accepted every cycle while m_axis is not stalled.
// A stall on m_axis holds the result register and, once the input register is also
// full, drops s_axis_tready. Reset clears both valid flags.
module intra4x4_luma_predictor_core (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           s_axis_tvalid,
    output logic          s_axis_tready,
    // [3:0] block_index, [4] top_edge, [5] left_edge, [6] top_left_edge,
    // [7] top_right_edge, [71:8] above_pixels, [103:72] left_pixels,
    // [111:104] corner_pixel
    input  wire  [111:0]  s_axis_tdata,
    // [3:0] mode
    input  wire  [3:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  wire           m_axis_tready,
    // [31:0] row0, [63:32] row1, [95:64] row2, [127:96] row3
    output logic [127:0]  m_axis_tdata
);
    import i4p_pkg::*;

    t_req   r_req;
    logic   r_req_valid;
    logic   n_req_valid;
    t_rows  r_rows;
    logic   r_out_valid;
    logic   n_out_valid;
    t_rows  pred_rows;
    logic   out_advance;

    // The result register frees up when it is empty or being taken this cycle.
    assign out_advance   = ~r_out_valid | m_axis_tready;
    assign s_axis_tready = ~r_req_valid | out_advance;

    assign n_req_valid = s_axis_tready ? s_axis_tvalid : r_req_valid;
    assign n_out_valid = out_advance ? r_req_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_req_valid <= n_req_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_req.mode           <= s_axis_tuser;
            r_req.block_index    <= s_axis_tdata[3:0];
            r_req.top_edge       <= s_axis_tdata[4];
            r_req.left_edge      <= s_axis_tdata[5];
            r_req.top_left_edge  <= s_axis_tdata[6];
            r_req.top_right_edge <= s_axis_tdata[7];
            r_req.above_pixels   <= s_axis_tdata[71:8];
            r_req.left_pixels    <= s_axis_tdata[103:72];
            r_req.corner_pixel   <= s_axis_tdata[111:104];
        end
        if (out_advance && r_req_valid) begin
            r_rows <= pred_rows;
        end
    end

    i4p_pred u_pred (
        .i_req  (r_req),
        .o_rows (pred_rows)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_rows;

endmodule

`default_nettype wire

// ===== verif/intra4x4_luma_predictor_core_tb.sv =====
// Self-checking testbench for the intra 4x4 luma predictor core.
`timescale 1ns / 100ps

module intra4x4_luma_predictor_core_tb;

    import i4p_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles with no item moving on either side
    localparam int HOLD_CYCLES = 300;   // long output stall used to fill the core
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [3:0]  mode;
        logic [3:0]  blk_idx;
        logic        top_edge;
        logic        left_edge;
        logic        top_left_edge;
        logic        top_right_edge;
        logic [63:0] above;
        logic [31:0] left;
        logic [7:0]  corner;
    } blk_req_t;

    typedef struct packed {
        logic up;
        logic left;
        logic up_left;
        logic up_right;
    } nbr_avail_t;

    typedef struct packed {
        logic [7:0][7:0] top;
        logic [3:0][7:0] lft;
        logic [7:0]      cor;
    } nbr_set_t;

    typedef enum int {
        RX_ALWAYS,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_style_e;

    typedef enum int {
        PIX_RANDOM,
        PIX_ALL_ONES,
        PIX_ALL_ZEROS,
        PIX_CORNERS
    } pix_style_e;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [111:0]   s_axis_tdata = '0;
    logic [3:0]     s_axis_tuser = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [127:0]   m_axis_tdata;

    logic [127:0]   pending_rows[$];
    int             mismatches = 0;
    int             blocks_sent = 0;
    int             rows_checked = 0;
    int             quiet_cycles = 0;
    int             burst_left = 0;
    bit             bursty = 1'b0;
    bit             hold_off_req = 1'b0;

    intra4x4_luma_predictor_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    // Which neighbours exist for a 4x4 block, given its position in the
    // macroblock and which surrounding macroblocks are missing.
    function automatic nbr_avail_t block_avail(logic [3:0] idx, logic te, logic le,
                                               logic tle, logic tre);
        nbr_avail_t a;
        logic       t;
        logic       l;
        t = ~te;
        l = ~le;
        case (idx)
            4'd0: begin
                a = '{up: t, left: l, up_left: t | l, up_right: t};
                if (tle) begin
                    a.up_left = 1'b0;
                end
            end
            4'd1, 4'd4: a = '{up: t, left: 1'b1, up_left: t, up_right: t};
            4'd5: a = '{up: t, left: 1'b1, up_left: t, up_right: t & ~tre};
            4'd2, 4'd8, 4'd10: a = '{up: 1'b1, left: l, up_left: l, up_right: 1'b1};
            4'd6, 4'd9, 4'd12, 4'd14: a = '{up: 1'b1, left: 1'b1, up_left: 1'b1, up_right: 1'b1};
            default: a = '{up: 1'b1, left: 1'b1, up_left: 1'b1, up_right: 1'b0};
        endcase
        return a;
    endfunction

    // y < 0 addresses the row above (x < 0 being the corner), otherwise the left column.
    function automatic int nbr_px(nbr_set_t n, int x, int y);
        if (y < 0) begin
            return (x < 0) ? int'(n.cor) : int'(n.top[x & 7]);
        end
        return int'(n.lft[y & 3]);
    endfunction

    function automatic int mean2(int a, int b);
        return (a + b + 1) >> 1;
    endfunction

    function automatic int mean3(int a, int b, int c);
        return (a + 2 * b + c + 2) >> 2;
    endfunction

    function automatic int pred_px(logic [3:0] mode, int x, int y, nbr_set_t n, int dc);
        int z;
        int h;
        z = 0;
        h = 0;
        case (mode)
            MODE_VERT: return nbr_px(n, x, -1);
            MODE_HOR:  return nbr_px(n, -1, y);
            MODE_DC:   return dc;
            MODE_DDL: begin
                if (x == 3 && y == 3) begin
                    return (nbr_px(n, 6, -1) + 3 * nbr_px(n, 7, -1) + 2) >> 2;
                end
                return mean3(nbr_px(n, x + y, -1), nbr_px(n, x + y + 1, -1),
                             nbr_px(n, x + y + 2, -1));
            end
            MODE_DDR: begin
                if (x > y) begin
                    return mean3(nbr_px(n, x - y - 2, -1), nbr_px(n, x - y - 1, -1),
                                 nbr_px(n, x - y, -1));
                end
                if (x < y) begin
                    return mean3(nbr_px(n, -1, y - x - 2), nbr_px(n, -1, y - x - 1),
                                 nbr_px(n, -1, y - x));
                end
                return mean3(nbr_px(n, 0, -1), nbr_px(n, -1, -1), nbr_px(n, -1, 0));
            end
            MODE_VR: begin
                z = 2 * x - y;
                h = x - (y >> 1);
                if (z >= 0 && (z & 1) == 0) begin
                    return mean2(nbr_px(n, h - 1, -1), nbr_px(n, h, -1));
                end
                if (z > 0) begin
                    return mean3(nbr_px(n, h - 2, -1), nbr_px(n, h - 1, -1), nbr_px(n, h, -1));
                end
                if (z == -1) begin
                    return mean3(nbr_px(n, -1, 0), nbr_px(n, -1, -1), nbr_px(n, 0, -1));
                end
                return mean3(nbr_px(n, -1, y - 1), nbr_px(n, -1, y - 2), nbr_px(n, -1, y - 3));
            end
            MODE_HD: begin
                z = 2 * y - x;
                h = y - (x >> 1);
                if (z >= 0 && (z & 1) == 0) begin
                    return mean2(nbr_px(n, -1, h - 1), nbr_px(n, -1, h));
                end
                if (z > 0) begin
                    return mean3(nbr_px(n, -1, h - 2), nbr_px(n, -1, h - 1), nbr_px(n, -1, h));
                end
                if (z == -1) begin
                    return mean3(nbr_px(n, -1, 0), nbr_px(n, -1, -1), nbr_px(n, 0, -1));
                end
                return mean3(nbr_px(n, x - 1, -1), nbr_px(n, x - 2, -1), nbr_px(n, x - 3, -1));
            end
            MODE_VL: begin
                h = x + (y >> 1);
                if ((y & 1) == 0) begin
                    return mean2(nbr_px(n, h, -1), nbr_px(n, h + 1, -1));
                end
                return mean3(nbr_px(n, h, -1), nbr_px(n, h + 1, -1), nbr_px(n, h + 2, -1));
            end
            MODE_HU: begin
                z = x + 2 * y;
                h = y + (x >> 1);
                if (z < 5 && (z & 1) == 0) begin
                    return mean2(nbr_px(n, -1, h), nbr_px(n, -1, h + 1));
                end
                if (z < 5) begin
                    return mean3(nbr_px(n, -1, h), nbr_px(n, -1, h + 1), nbr_px(n, -1, h + 2));
                end
                if (z == 5) begin
                    return (nbr_px(n, -1, 2) + 3 * nbr_px(n, -1, 3) + 2) >> 2;
                end
                return nbr_px(n, -1, 3);
            end
            default: return 0;
        endcase
    endfunction

    // Four predicted rows for one block, row 0 in the lowest 32 bits.
    function automatic logic [127:0] predict_rows(blk_req_t b);
        nbr_avail_t   av;
        nbr_set_t     n;
        int           dc;
        int           top_sum;
        int           left_sum;
        logic [127:0] rows;
        av = block_avail(b.blk_idx, b.top_edge, b.left_edge, b.top_left_edge,
                         b.top_right_edge);
        for (int i = 0; i < 4; i++) begin
            n.top[i] = av.up ? b.above[8*i +: 8] : PIX_MID;
            n.lft[i] = av.left ? b.left[8*i +: 8] : PIX_MID;
        end
        // A missing up-right run repeats pixel D, after D's own substitution.
        for (int i = 4; i < 8; i++) begin
            n.top[i] = av.up_right ? b.above[8*i +: 8] : n.top[3];
        end
        n.cor = av.up_left ? b.corner : PIX_MID;

        top_sum = 0;
        left_sum = 0;
        for (int i = 0; i < 4; i++) begin
            top_sum += int'(n.top[i]);
            left_sum += int'(n.lft[i]);
        end
        if (av.up && av.left) begin
            dc = (top_sum + left_sum + 4) >> 3;
        end else if (av.up) begin
            dc = (top_sum + 2) >> 2;
        end else if (av.left) begin
            dc = (left_sum + 2) >> 2;
        end else begin
            dc = int'(PIX_MID);
        end

        for (int y = 0; y < 4; y++) begin
            for (int x = 0; x < 4; x++) begin
                rows[32*y + 8*x +: 8] = 8'(pred_px(b.mode, x, y, n, dc));
            end
        end
        return rows;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic logic [7:0] rand_byte(pix_style_e style);
        logic [7:0] picks[6];
        picks = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
        case (style)
            PIX_ALL_ONES:  return 8'hFF;
            PIX_ALL_ZEROS: return 8'h00;
            PIX_CORNERS:   return picks[$urandom_range(5, 0)];
            default:       return 8'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic blk_req_t fill_pixels(blk_req_t b, pix_style_e style);
        for (int i = 0; i < 8; i++) begin
            b.above[8*i +: 8] = rand_byte(style);
        end
        for (int i = 0; i < 4; i++) begin
            b.left[8*i +: 8] = rand_byte(style);
        end
        b.corner = rand_byte(style);
        return b;
    endfunction

    function automatic pix_style_e pick_pix_style();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) begin
            return PIX_RANDOM;
        end else if (r < 80) begin
            return PIX_ALL_ONES;
        end else if (r < 88) begin
            return PIX_ALL_ZEROS;
        end
        return PIX_CORNERS;
    endfunction

    function automatic blk_req_t make_block(logic [3:0] mode, logic [3:0] idx, logic te,
                                            logic le, logic tle, logic tre,
                                            pix_style_e style);
        blk_req_t b;
        b = '0;
        b.mode = mode;
        b.blk_idx = idx;
        b.top_edge = te;
        b.left_edge = le;
        b.top_left_edge = tle;
        b.top_right_edge = tre;
        return fill_pixels(b, style);
    endfunction

    // Mostly the nine real modes, now and then one of the unused codes.
    function automatic logic [3:0] pick_mode();
        if ($urandom_range(9, 0) == 0) begin
            return 4'($urandom_range(15, 9));
        end
        return 4'($urandom_range(MODE_HU, MODE_VERT));
    endfunction

    function automatic blk_req_t rand_block();
        logic [3:0] edges;
        edges = 4'($urandom_range(15, 0));
        return make_block(pick_mode(), 4'($urandom_range(15, 0)), edges[0], edges[1],
                          edges[2], edges[3], pick_pix_style());
    endfunction

    // Offers one block and waits for it to be taken. Valid is left high so
    // that back-to-back blocks go out on consecutive cycles.
    task automatic send_block(blk_req_t b);
        if (bursty) begin
            if (burst_left == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(7, 1)) @(posedge i_clk);
                burst_left = $urandom_range(24, 1);
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.corner, b.left, b.above, b.top_right_edge,
                          b.top_left_edge, b.left_edge, b.top_edge, b.blk_idx};
        s_axis_tuser  <= b.mode;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        pending_rows.push_back(predict_rows(b));
        blocks_sent++;
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Every mode, unused codes, each substitution rule and saturating pixel values.
    task automatic test_directed_cases();
        bursty = 1'b0;
        for (int m = MODE_VERT; m <= MODE_HU; m++) begin
            send_block(make_block(4'(m), 4'd6, 1'b0, 1'b0, 1'b0, 1'b0, PIX_RANDOM));
        end
        send_block(make_block(4'd9, 4'd6, 1'b0, 1'b0, 1'b0, 1'b0, PIX_RANDOM));
        send_block(make_block(4'd15, 4'd9, 1'b1, 1'b1, 1'b1, 1'b1, PIX_ALL_ONES));
        // DC with nothing around it, then with only the left or only the top.
        send_block(make_block(MODE_DC, 4'd0, 1'b1, 1'b1, 1'b0, 1'b0, PIX_RANDOM));
        send_block(make_block(MODE_DC, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0, PIX_RANDOM));
        send_block(make_block(MODE_DC, 4'd0, 1'b0, 1'b1, 1'b0, 1'b0, PIX_RANDOM));
        // Up-right never available inside the macroblock here: E..H copy D.
        send_block(make_block(MODE_DDL, 4'd3, 1'b0, 1'b0, 1'b0, 1'b0, PIX_RANDOM));
        send_block(make_block(MODE_VR, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0, PIX_RANDOM));
        send_block(make_block(MODE_VL, 4'd5, 1'b0, 1'b0, 1'b0, 1'b1, PIX_RANDOM));
        send_block(make_block(MODE_HD, 4'd2, 1'b0, 1'b1, 1'b0, 1'b0, PIX_RANDOM));
        send_block(make_block(MODE_VERT, 4'd1, 1'b1, 1'b0, 1'b0, 1'b0, PIX_RANDOM));
        send_block(make_block(MODE_DC, 4'd9, 1'b0, 1'b0, 1'b0, 1'b0, PIX_ALL_ONES));
        send_block(make_block(MODE_DDR, 4'd12, 1'b0, 1'b0, 1'b0, 1'b0, PIX_ALL_ZEROS));
        send_block(make_block(MODE_DDL, 4'd14, 1'b0, 1'b0, 1'b0, 1'b0, PIX_ALL_ONES));
        send_block(make_block(MODE_HU, 4'd6, 1'b0, 1'b0, 1'b0, 1'b0, PIX_ALL_ONES));
    endtask

    // Every block position against every combination of the top, left, top-left and top-right edge bits.
    task automatic test_position_sweep();
        bursty = 1'b1;
        for (int idx = 0; idx < 16; idx++) begin
            for (int e = 0; e < 16; e++) begin
                send_block(make_block(4'($urandom_range(MODE_HU, MODE_VERT)), 4'(idx),
                                      e[0], e[1], e[2], e[3], pick_pix_style()));
            end
        end
    endtask

    task automatic test_random_blocks(int count);
        bursty = 1'b1;
        repeat (count) send_block(rand_block());
    endtask

    // The receiver holds off for a long stretch while blocks keep coming, so
    // both registers fill and the input side has to stall.
    task automatic test_output_stall(int count);
        bursty = 1'b0;
        hold_off_req = 1'b1;
        repeat (count) send_block(rand_block());
    endtask

    task automatic test_full_rate(int count);
        bursty = 1'b0;
        repeat (count) send_block(rand_block());
    endtask

    // ---------------------------------------------------------------------
    // Receiver pacing
    // ---------------------------------------------------------------------

    initial begin : rx_pacing
        rx_style_e style;
        int        cycle_cnt;
        style = RX_ALWAYS;
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                style = RX_ALWAYS;
            end
            cycle_cnt++;
            if (cycle_cnt % 150 == 0) begin
                style = rx_style_e'($urandom_range(RX_PERIODIC, RX_ALWAYS));
            end
            case (style)
                RX_LIGHT:    m_axis_tready <= ($urandom_range(3, 0) != 0);
                RX_HEAVY:    m_axis_tready <= ($urandom_range(3, 0) == 0);
                RX_PERIODIC: m_axis_tready <= ((cycle_cnt % 5) < 3);
                default:     m_axis_tready <= 1'b1;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Result checking and watchdog
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected result %h with no block outstanding", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_rows.pop_front();
                for (int r = 0; r < 4; r++) begin
                    if (m_axis_tdata[32*r +: 32] !== want[32*r +: 32]) begin
                        $error("row%0d: expected %h, got %h", r, want[32*r +: 32],
                               m_axis_tdata[32*r +: 32]);
                        mismatches++;
                    end
                end
                rows_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_rows.size());
            $display("intra4x4_luma_predictor_core: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial begin : main_seq
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_position_sweep();
        test_random_blocks(1000);
        test_output_stall(60);
        test_full_rate(80);

        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_rows.size() != 0) begin
            $error("%0d results never arrived", pending_rows.size());
            mismatches++;
        end
        $display("Sent %0d blocks and checked %0d predictions: all modes and unused codes,",
                 blocks_sent, rows_checked);
        $display("every block position and edge pattern, bursty input and a long output stall.");
        if (mismatches == 0) begin
            $display("intra4x4_luma_predictor_core: match");
        end else begin
            $display("intra4x4_luma_predictor_core: mismatch");
        end
        $finish;
    end

endmodule
